/* rtl/acc_alu_pkg.sv */
// Shared types and constants for the accumulator integer ALU.
// Opcodes, status codes, and the request/response structs of the shared unit.
// No dependencies.
package acc_alu_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_MOD0 = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2
    } t_fn;

    typedef struct packed {
        t_fn   fn;
        t_word x;
        t_word y;
    } t_unit_req;

    typedef struct packed {
        t_word res;
        logic  borrow;
    } t_unit_rsp;

endpackage

/* rtl/acc_alu_unit.sv */
// Shared arithmetic unit: add, subtract with borrow out, wrapping multiply.
// Time-shared by the sequencer in accumulator_integer_alu.
// Depends on acc_alu_pkg.
module acc_alu_unit (
    input  acc_alu_pkg::t_unit_req i_req,
    output acc_alu_pkg::t_unit_rsp o_rsp
);
    import acc_alu_pkg::*;

    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] prod;

    always_comb begin
        diff = {1'b0, i_req.x} - {1'b0, i_req.y};
        sum  = i_req.x + i_req.y;
        prod = i_req.x * i_req.y;
        case (i_req.fn)
            FN_ADD: begin
                o_rsp.res    = sum;
                o_rsp.borrow = 1'b0;
            end
            FN_SUB: begin
                o_rsp.res    = diff[DATA_W-1:0];
                o_rsp.borrow = diff[DATA_W];
            end
            FN_MUL: begin
                o_rsp.res    = prod;
                o_rsp.borrow = 1'b0;
            end
            default: begin
                o_rsp.res    = sum;
                o_rsp.borrow = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/accumulator_integer_alu.sv */
// Accumulator integer ALU: sequencer, accumulator and output register.
// Instantiates acc_alu_unit; depends on acc_alu_pkg.
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+------------------------------------------
//  input   | in        | i_valid / o_stall | i_op, i_two_operands, i_operand_a/b
//  output  | out       | o_valid / i_stall | o_value, o_status
//
// Per word: add, subtract, multiply, spare opcodes, zero divisors and negative exponents
// go straight to done; divide and modulo take magnitudes, do one restoring step per cycle
// per bit, then fix sign; power multiplies and squares per exponent bit to its top set bit.
// o_stall is high from acceptance until the result enters the output register.
// A result waits in the output register while the next word is accepted.
// Reset is synchronous; it clears the accumulator and empties the output.
module accumulator_integer_alu (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [acc_alu_pkg::OP_W-1:0]           i_op,
    input  logic                                   i_two_operands,
    input  logic signed [acc_alu_pkg::DATA_W-1:0]  i_operand_a,
    input  logic signed [acc_alu_pkg::DATA_W-1:0]  i_operand_b,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [acc_alu_pkg::DATA_W-1:0]  o_value,
    output logic [acc_alu_pkg::ST_W-1:0]           o_status
);
    import acc_alu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ABSR,
        S_DIV,
        S_SIGN,
        S_PMUL,
        S_PSQR,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    t_word            r_left, n_left;
    t_word            r_right, n_right;
    t_word            r_aux, n_aux;
    t_word            r_res, n_res;
    t_word            r_acc, n_acc;
    logic             r_lneg, n_lneg;
    logic             r_rneg, n_rneg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_status          r_st, n_st;
    logic             r_out_valid, n_out_valid;
    t_word            r_out_value, n_out_value;
    t_status          r_out_status, n_out_status;

    t_unit_req        unit_req;
    t_unit_rsp        unit_rsp;
    t_word            shifted;
    t_word            mag;
    logic             neg;

    acc_alu_unit u_unit (
        .i_req (unit_req),
        .o_rsp (unit_rsp)
    );

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_left       = r_left;
        n_right      = r_right;
        n_aux        = r_aux;
        n_res        = r_res;
        n_acc        = r_acc;
        n_lneg       = r_lneg;
        n_rneg       = r_rneg;
        n_cnt        = r_cnt;
        n_st         = r_st;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        unit_req.fn  = FN_SUB;
        unit_req.x   = '0;
        unit_req.y   = '0;
        shifted      = {r_aux[DATA_W-2:0], r_left[DATA_W-1]};
        mag          = (r_op == OP_DIV) ? r_left : r_aux;
        neg          = (r_op == OP_DIV) ? (r_lneg ^ r_rneg) : r_lneg;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_left  = i_two_operands ? $unsigned(i_operand_a) : r_acc;
                    n_right = i_two_operands ? $unsigned(i_operand_b)
                                             : $unsigned(i_operand_a);
                    n_lneg  = n_left[DATA_W-1];
                    n_rneg  = n_right[DATA_W-1];
                    n_op    = t_op'(i_op);
                    n_st    = ST_OK;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ADD, OP_SUB, OP_MUL: begin
                        unit_req.fn = (r_op == OP_ADD) ? FN_ADD :
                                      (r_op == OP_SUB) ? FN_SUB : FN_MUL;
                        unit_req.x  = r_left;
                        unit_req.y  = r_right;
                        n_res       = unit_rsp.res;
                        n_state     = S_DONE;
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_right == '0) begin
                            n_st    = (r_op == OP_DIV) ? ST_DIV0 : ST_MOD0;
                            n_res   = r_acc;
                            n_state = S_DONE;
                        end else begin
                            unit_req.y = r_left;
                            if (r_lneg) begin
                                n_left = unit_rsp.res;
                            end
                            n_state = S_ABSR;
                        end
                    end
                    OP_POW: begin
                        if (r_right[DATA_W-1]) begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end else begin
                            n_aux   = t_word'(1);
                            n_state = S_PMUL;
                        end
                    end
                    default: begin
                        n_res   = r_acc;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ABSR: begin
                unit_req.y = r_right;
                if (r_rneg) begin
                    n_right = unit_rsp.res;
                end
                n_aux   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                unit_req.x = shifted;
                unit_req.y = r_right;
                n_aux      = unit_rsp.borrow ? shifted : unit_rsp.res;
                n_left     = {r_left[DATA_W-2:0], !unit_rsp.borrow};
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                unit_req.y = mag;
                n_res      = neg ? unit_rsp.res : mag;
                n_state    = S_DONE;
            end
            S_PMUL: begin
                if (r_right == '0) begin
                    n_res   = r_aux;
                    n_state = S_DONE;
                end else begin
                    unit_req.fn = FN_MUL;
                    unit_req.x  = r_aux;
                    unit_req.y  = r_left;
                    if (r_right[0]) begin
                        n_aux = unit_rsp.res;
                    end
                    n_state = S_PSQR;
                end
            end
            S_PSQR: begin
                unit_req.fn = FN_MUL;
                unit_req.x  = r_left;
                unit_req.y  = r_left;
                n_left      = unit_rsp.res;
                n_right     = r_right >> 1;
                n_state     = S_PMUL;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res;
                    n_out_status = r_st;
                    n_acc        = r_res;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_left       <= n_left;
        r_right      <= n_right;
        r_aux        <= n_aux;
        r_res        <= n_res;
        r_lneg       <= n_lneg;
        r_rneg       <= n_rneg;
        r_cnt        <= n_cnt;
        r_st         <= n_st;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc       <= n_acc;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = $signed(r_out_value);
    assign o_status = r_out_status;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state == S_EXEC)
        else $error("accepted word did not start execution");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_aux < r_right)
        else $error("partial remainder not below divisor");

    a_out_matches_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_value == r_acc)
        else $error("pending result differs from accumulator");

endmodule

/* dv/tb.sv */
// Self-checking testbench for accumulator_integer_alu: directed table, then random words,
// checked against an in-bench accumulator predictor with random idling and stall pressure.
// Depends on rtl/acc_alu_pkg.sv and rtl/accumulator_integer_alu.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acc_alu_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam t_word WORD_MIN = 32'h8000_0000;
    localparam t_word WORD_MAX = 32'h7FFF_FFFF;
    localparam t_word WORD_M1  = 32'hFFFF_FFFF;
    localparam int RANDOM_WORDS = 730;
    localparam int STEADY_WORDS = 100;
    localparam int DRAIN_AT     = 400;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 40;
    localparam int TAIL_CYCLES  = 80;

    typedef struct packed {
        t_word   value;
        t_status status;
    } t_acc_result;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            two;
        t_word           a;
        t_word           b;
        logic            typed;
        t_word           value;
        t_status         status;
    } t_stim_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    logic [OP_W-1:0] i_op = '0;
    logic            i_two_operands = 1'b0;
    t_word           i_operand_a = '0;
    t_word           i_operand_b = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    t_word           o_value;
    logic [ST_W-1:0] o_status;

    t_word       acc_shadow;
    t_acc_result acc_results_q[$];
    int          errors = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          zero_div_seen = 0;
    int          op_count[8];
    bit          steady = 1'b0;

    t_stim_row dir_rows[22] = '{
        '{OP_DIV,    1'b0, 32'd0,    WORD_M1,  1'b1, 32'd0,    ST_DIV0},
        '{OP_MOD,    1'b0, 32'd0,    32'd9,    1'b1, 32'd0,    ST_MOD0},
        '{OP_ADD,    1'b1, WORD_MAX, 32'd1,    1'b1, WORD_MIN, ST_OK},
        '{OP_SUB,    1'b1, WORD_MIN, 32'd1,    1'b1, WORD_MAX, ST_OK},
        '{OP_DIV,    1'b1, WORD_MIN, WORD_M1,  1'b1, WORD_MIN, ST_OK},
        '{OP_MOD,    1'b1, WORD_MIN, WORD_M1,  1'b1, 32'd0,    ST_OK},
        '{OP_POW,    1'b1, 32'd0,    32'd0,    1'b1, 32'd1,    ST_OK},
        '{OP_POW,    1'b1, 32'd7,    WORD_M1,  1'b1, 32'd0,    ST_OK},
        '{OP_DIV,    1'b0, 32'd0,    WORD_MAX, 1'b1, 32'd0,    ST_DIV0},
        '{OP_MUL,    1'b1, WORD_M1,  WORD_M1,  1'b1, 32'd1,    ST_OK},
        '{OP_ADD,    1'b0, WORD_MAX, WORD_MIN, 1'b0, 32'd0,    ST_OK},
        '{OP_SPARE6, 1'b0, 32'd3,    32'd4,    1'b0, 32'd0,    ST_OK},
        '{OP_SPARE7, 1'b1, WORD_M1,  32'd0,    1'b0, 32'd0,    ST_OK},
        '{OP_MOD,    1'b1, -32'sd7,  32'd2,    1'b0, 32'd0,    ST_OK},
        '{OP_DIV,    1'b1, 32'd7,    -32'sd2,  1'b0, 32'd0,    ST_OK},
        '{OP_MUL,    1'b0, -32'sd3,  WORD_M1,  1'b0, 32'd0,    ST_OK},
        '{OP_POW,    1'b1, 32'd3,    WORD_MAX, 1'b0, 32'd0,    ST_OK},
        '{OP_POW,    1'b0, 32'd5,    32'h5A5A_A5A5, 1'b0, 32'd0, ST_OK},
        '{OP_SUB,    1'b0, WORD_MIN, 32'd0,    1'b0, 32'd0,    ST_OK},
        '{OP_MOD,    1'b0, WORD_MAX, WORD_M1,  1'b0, 32'd0,    ST_OK},
        '{OP_DIV,    1'b1, WORD_MAX, WORD_MIN, 1'b0, 32'd0,    ST_OK},
        '{OP_MOD,    1'b1, 32'd5,    32'd0,    1'b0, 32'd0,    ST_OK}
    };

    accumulator_integer_alu uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_two_operands (i_two_operands),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_value        (o_value),
        .o_status       (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic t_word abs_word(input t_word x);
        return x[DATA_W-1] ? -x : x;
    endfunction

    function automatic t_word wrap_power(input t_word base, input t_word expo);
        t_word prod;
        prod = 32'd1;
        if (expo[DATA_W-1]) begin
            return '0;
        end
        while (expo != 0) begin
            if (expo[0]) begin
                prod = prod * base;
            end
            base = base * base;
            expo = expo >> 1;
        end
        return prod;
    endfunction

    // Advances the shadow accumulator by one word and returns the expected result.
    function automatic t_acc_result compute_acc(input logic [OP_W-1:0] op, input logic two,
                                                input t_word a, input t_word b);
        t_word       left;
        t_word       right;
        t_acc_result r;
        left     = two ? a : acc_shadow;
        right    = two ? b : a;
        r.status = ST_OK;
        case (op)
            OP_ADD: acc_shadow = left + right;
            OP_SUB: acc_shadow = left - right;
            OP_MUL: acc_shadow = left * right;
            OP_DIV: begin
                if (right == 0) begin
                    r.status = ST_DIV0;
                end else begin
                    acc_shadow = abs_word(left) / abs_word(right);
                    if (left[DATA_W-1] ^ right[DATA_W-1]) begin
                        acc_shadow = -acc_shadow;
                    end
                end
            end
            OP_MOD: begin
                if (right == 0) begin
                    r.status = ST_MOD0;
                end else begin
                    acc_shadow = abs_word(left) % abs_word(right);
                    if (left[DATA_W-1]) begin
                        acc_shadow = -acc_shadow;
                    end
                end
            end
            OP_POW: acc_shadow = wrap_power(left, right);
            default: ;
        endcase
        r.value = acc_shadow;
        return r;
    endfunction

    function automatic t_word pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return WORD_M1;
            3: return WORD_MIN;
            4: return WORD_MAX;
            5, 6: return t_word'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_word pick_exponent();
        case ($urandom_range(0, 15))
            0: return $urandom;
            1: return WORD_MAX;
            2: return WORD_MIN | $urandom;
            default: return $urandom_range(0, 33);
        endcase
    endfunction

    function automatic t_stim_row random_row();
        t_stim_row r;
        t_word     right;
        r     = '0;
        r.op  = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(6, 7))
                                             : OP_W'($urandom_range(0, 5));
        r.two = 1'($urandom_range(0, 1));
        r.a   = pick_operand();
        r.b   = r.two ? pick_operand() : $urandom;
        right = r.two ? r.b : r.a;
        if (r.op == OP_POW) begin
            right = pick_exponent();
        end else if ((r.op == OP_DIV || r.op == OP_MOD) && $urandom_range(0, 7) == 0) begin
            right = '0;
        end
        if (r.two) begin
            r.b = right;
        end else begin
            r.a = right;
        end
        return r;
    endfunction

    task automatic send_word(input t_stim_row row);
        t_acc_result r;
        i_valid        <= 1'b1;
        i_op           <= row.op;
        i_two_operands <= row.two;
        i_operand_a    <= row.a;
        i_operand_b    <= row.b;
        do @(posedge i_clk); while (o_stall);
        r = compute_acc(row.op, row.two, row.a, row.b);
        if (row.typed) begin
            r.value  = row.value;
            r.status = row.status;
        end
        acc_results_q.push_back(r);
        words_sent++;
        op_count[row.op]++;
    endtask

    task automatic sender_idle(input int cycles);
        i_valid        <= 1'b0;
        i_op           <= OP_W'($urandom);
        i_two_operands <= 1'($urandom);
        i_operand_a    <= $urandom;
        i_operand_b    <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    initial begin : stimulus
        acc_shadow = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k]);
            if ($urandom_range(0, 3) == 0) begin
                sender_idle($urandom_range(1, 19));
            end
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - STEADY_WORDS) begin
                steady = 1'b1;
            end
            if (n == DRAIN_AT) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (acc_results_q.size() != 0);
            end
            send_word(random_row());
            if (!steady && $urandom_range(0, 3) == 0) begin
                sender_idle($urandom_range(1, 19));
            end
        end
        i_valid <= 1'b0;
        while (acc_results_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("tb: %0d words sent, %0d results checked, %0d divide/modulo by zero",
                 words_sent, results_seen, zero_div_seen);
        $display("tb: add %0d sub %0d mul %0d div %0d mod %0d pow %0d spare %0d",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
                 op_count[OP_MOD], op_count[OP_POW],
                 op_count[OP_SPARE6] + op_count[OP_SPARE7]);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off to back the block up.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                repeat ($urandom_range(0, 30)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_acc_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_status != ST_OK) begin
                zero_div_seen++;
            end
            if (acc_results_q.size() == 0) begin
                $error("unexpected word: value %h status %0d", o_value, o_status);
                errors++;
            end else begin
                exp_r = acc_results_q.pop_front();
                if (o_value !== exp_r.value) begin
                    $error("value: expected %h, actual %h", exp_r.value, o_value);
                    errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    errors++;
                end
            end
        end
    end

endmodule

/* accumulator_integer_alu.f */
rtl/acc_alu_pkg.sv
rtl/acc_alu_unit.sv
rtl/accumulator_integer_alu.sv
dv/tb.sv
